/* hdl/modinv_pkg.sv */
package modinv_pkg;

    // Value of the modulus register after reset (1e9 + 7).
    localparam logic [31:0] MOD_RESET = 32'd1000000007;

    // Register numbers on the configuration port.
    localparam logic REG_MODULUS = 1'b0;

    // Operations of the shared compare and subtract unit.
    typedef enum logic
    {
        ALU_CMP,
        ALU_CSUB
    } alu_op_t;

    // Sequencer states.
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_REDUCE,
        ST_LOOP,
        ST_ALIGN,
        ST_DIVIDE,
        ST_FIX
    } state_t;

endpackage

/* hdl/modinv_alu.sv */
module modinv_alu
    import modinv_pkg::*;
#(
    parameter int W = 32
)
(
    input  alu_op_t        op,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           ge,
    output logic [W-1:0]   y
);

    logic [W:0] diff;

    // One subtractor serves the compare and the conditional subtract.
    assign diff = {1'b0, a} - {1'b0, b};
    assign ge   = ~diff[W];

    always_comb
    begin
        case (op)
            ALU_CSUB: y = ge ? diff[W-1:0] : a;
            ALU_CMP:  y = a;
            default:  y = a;
        endcase
    end

endmodule

/* hdl/modular_inverse.sv */
// Channel   Direction  Signals                               Transfer
// config    in/out     psel penable pwrite paddr pwdata       psel & penable & pwrite & pready
//                      prdata pready
// command   in         start value                           start & !busy
// result    out        done inverse no_inverse               done (one cycle, no stall)
//
// An item is accepted only while the block is idle, and the next command may be accepted at
// the edge that takes the result, so one value is fully processed before the next is taken.
// The value is first reduced bit-serially by the modulus, then extended Euclid runs with
// each quotient found bit by bit on the one shared compare/subtract unit. A zero modulus or a
// value equal to it needs no iteration. Reset is asynchronous, active low, and loads 1e9 + 7;
// the result cannot be stalled and lives only while done is high.
module modular_inverse
    import modinv_pkg::*;
#(
    parameter int VALUE_BITS = 63,
    parameter int MOD_BITS   = 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Command
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_BITS-1:0]  value,
    // Result
    output logic                   done,
    output logic [MOD_BITS-1:0]    inverse,
    output logic                   no_inverse
);

    // Width of the remainder datapath, with one bit of headroom for shifts.
    localparam int AW = MOD_BITS + 1;
    // Signed width of the Bezout coefficients; their magnitude stays below twice the modulus.
    localparam int TW = MOD_BITS + 3;
    localparam int CW = $clog2(VALUE_BITS);
    localparam int KW = (MOD_BITS > 2) ? $clog2(MOD_BITS) : 1;
    // Common width for comparing the value against the modulus.
    localparam int EW = (VALUE_BITS > MOD_BITS) ? VALUE_BITS : MOD_BITS;

    state_t                  state_reg, state_next;
    logic [MOD_BITS-1:0]     modulus_reg, modulus_next;
    logic [VALUE_BITS-1:0]   v_reg, v_next;
    logic [MOD_BITS-1:0]     m_reg, m_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [MOD_BITS-1:0]     rem_reg, rem_next;
    logic [MOD_BITS-1:0]     d_reg, d_next;
    logic [MOD_BITS-1:0]     r0_reg, r0_next;
    logic [MOD_BITS-1:0]     r1_reg, r1_next;
    logic [KW-1:0]           k_reg, k_next;
    logic signed [TW-1:0]    t0_reg, t0_next;
    logic signed [TW-1:0]    t1_reg, t1_next;
    logic signed [TW-1:0]    tt_reg, tt_next;
    logic signed [TW-1:0]    tacc_reg, tacc_next;
    logic [MOD_BITS-1:0]     inv_reg, inv_next;
    logic                    flag_reg, flag_next;
    logic                    done_reg, done_next;

    alu_op_t                 alu_op;
    logic [AW-1:0]           alu_a, alu_b, alu_y;
    logic                    alu_ge;

    logic                    accept;
    logic                    cfg_write;
    logic signed [TW-1:0]    m_s;
    logic signed [TW-1:0]    t_fix;
    logic signed [TW-1:0]    tacc_sub;

    // ------------------------------------------------------------------
    // Configuration port. Only the modulus register exists, decoded from
    // paddr[2] alone; writes with paddr[2] set are dropped, reads return zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        modulus_next = modulus_reg;
        if (cfg_write && paddr[2] == REG_MODULUS)
        begin
            modulus_next = pwdata[MOD_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MODULUS) ? 32'(modulus_reg) : 32'd0;

    // ------------------------------------------------------------------
    // Shared compare and subtract unit.
    // ------------------------------------------------------------------
    modinv_alu #(
        .W (AW)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .ge (alu_ge),
        .y  (alu_y)
    );

    assign accept   = start & ~busy;
    assign m_s      = signed'(TW'(m_reg));
    assign tacc_sub = tacc_reg - tt_reg;

    // Bring the final coefficient into 0..modulus-1. It never lies more than
    // one modulus away from that range, so one correction is enough.
    always_comb
    begin
        if (t0_reg < 0)
        begin
            t_fix = t0_reg + m_s;
        end
        else if (t0_reg >= m_s)
        begin
            t_fix = t0_reg - m_s;
        end
        else
        begin
            t_fix = t0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // A zero modulus, or a value equal to the modulus, needs no iteration.
                    if (modulus_reg == '0 || EW'(value) == EW'(modulus_reg))
                    begin
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                state_next = (r1_reg == '0) ? ST_FIX : ST_ALIGN;
            end
            ST_ALIGN:
            begin
                if (!alu_ge)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (k_reg == '0)
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_FIX:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: operands and operation of the shared unit.
    // ------------------------------------------------------------------
    always_comb
    begin
        alu_op = ALU_CMP;
        alu_a  = {1'b0, rem_reg};
        alu_b  = {1'b0, d_reg};
        case (state_reg)
            ST_REDUCE:
            begin
                // One step of restoring division of the value by the modulus.
                alu_op = ALU_CSUB;
                alu_a  = {rem_reg, v_reg[cnt_reg]};
                alu_b  = {1'b0, m_reg};
            end
            ST_ALIGN:
            begin
                // Does the divisor still fit under the remainder after one more shift?
                alu_op = ALU_CMP;
                alu_a  = {1'b0, rem_reg};
                alu_b  = {d_reg, 1'b0};
            end
            ST_DIVIDE:
            begin
                alu_op = ALU_CSUB;
                alu_a  = {1'b0, rem_reg};
                alu_b  = {1'b0, d_reg};
            end
            default:
            begin
                alu_op = ALU_CMP;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------
    // Datapath.
    // ------------------------------------------------------------------
    always_comb
    begin
        v_next    = v_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        k_next    = k_reg;
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        tt_next   = tt_reg;
        tacc_next = tacc_reg;
        inv_next  = inv_reg;
        flag_next = flag_reg;
        done_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    v_next   = value;
                    m_next   = modulus_reg;
                    cnt_next = CW'(VALUE_BITS - 1);
                    rem_next = '0;
                    if (modulus_reg == '0)
                    begin
                        // Zero coefficient, and a remainder that is not one raises the flag.
                        t0_next = '0;
                        r0_next = '0;
                    end
                    else
                    begin
                        // Value equal to the modulus: the algorithm leaves coefficient one.
                        t0_next = TW'(1);
                        r0_next = modulus_reg;
                    end
                end
            end
            ST_REDUCE:
            begin
                rem_next = alu_y[MOD_BITS-1:0];
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    r0_next = m_reg;
                    r1_next = alu_y[MOD_BITS-1:0];
                    t0_next = '0;
                    t1_next = TW'(1);
                end
            end
            ST_LOOP:
            begin
                rem_next  = r0_reg;
                d_next    = r1_reg;
                tt_next   = t1_reg;
                tacc_next = t0_reg;
                k_next    = '0;
            end
            ST_ALIGN:
            begin
                if (alu_ge)
                begin
                    d_next  = {d_reg[MOD_BITS-2:0], 1'b0};
                    tt_next = tt_reg <<< 1;
                    k_next  = k_reg + KW'(1);
                end
            end
            ST_DIVIDE:
            begin
                rem_next = alu_y[MOD_BITS-1:0];
                if (alu_ge)
                begin
                    tacc_next = tacc_sub;
                end
                if (k_reg == '0)
                begin
                    // Quotient complete: shift the remainder and coefficient pairs.
                    r0_next = r1_reg;
                    r1_next = alu_y[MOD_BITS-1:0];
                    t0_next = t1_reg;
                    t1_next = alu_ge ? tacc_sub : tacc_reg;
                end
                else
                begin
                    d_next  = d_reg >> 1;
                    tt_next = tt_reg >>> 1;
                    k_next  = k_reg - KW'(1);
                end
            end
            ST_FIX:
            begin
                inv_next  = t_fix[MOD_BITS-1:0];
                flag_next = (r0_reg != MOD_BITS'(1));
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            modulus_reg <= MOD_RESET[MOD_BITS-1:0];
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            modulus_reg <= modulus_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        m_reg    <= m_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        k_reg    <= k_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        tt_reg   <= tt_next;
        tacc_reg <= tacc_next;
        inv_reg  <= inv_next;
        flag_reg <= flag_next;
    end

    assign done       = done_reg;
    assign inverse    = inv_reg;
    assign no_inverse = flag_reg;

`ifndef SYNTHESIS
    // A result strobe lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // An accepted command always starts work.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted command did not make the block busy");

    // A valid inverse is always reduced below the modulus it was computed for.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !no_inverse) |-> (inverse < m_reg))
        else $error("inverse not reduced below the modulus");

    // The divisor is never shifted past the remainder it divides.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (d_reg <= r0_reg))
        else $error("aligned divisor exceeds the dividend");
`endif

endmodule

/* bench/tb_modular_inverse.sv */
module tb_modular_inverse;
    import modinv_pkg::*;

    // The modulus register is number zero, so it sits at byte address zero.
    localparam logic [2:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};

    // A transfer-free stretch this long means the block has hung.
    localparam int unsigned STALL_LIMIT = 4000;

    // Cycles to wait after the last result, to catch a stray extra strobe.
    localparam int unsigned DRAIN_CYCLES = 300;

    // Items per modulus setting in the random part.
    localparam int unsigned PHASE_ITEMS = 120;
    localparam int unsigned TRIVIAL_PHASE_ITEMS = 30;

    typedef struct packed {
        logic [30:0] inverse;
        logic        no_inverse;
    } inverse_result_t;

    // The scoreboard owns a private copy of the modulus register and a FIFO of
    // predicted results, one per accepted value.
    class inverse_scoreboard;
        logic [30:0]     modulus;
        inverse_result_t expected_q[$];
        int unsigned     failures;
        int unsigned     results_checked;
        int unsigned     no_inverse_seen;

        function new();
            modulus = MOD_RESET[30:0];
        endfunction

        function void set_modulus(logic [31:0] data);
            modulus = data[30:0];
        endfunction

        // Runs extended Euclid on (value mod m, m), exactly as the block should.
        function void note_value(logic [62:0] val);
            longint unsigned m;
            longint unsigned v;
            longint unsigned r0;
            longint unsigned r1;
            longint unsigned q;
            longint unsigned nr;
            longint          t0;
            longint          t1;
            longint          nt;
            longint          x;
            inverse_result_t res;
            m = longint'(modulus);
            v = {1'b0, val};
            if (m == 0) begin
                res.inverse    = '0;
                res.no_inverse = 1'b1;
            end
            else if (v == m) begin
                // The gcd is m itself and the coefficient left behind is 1.
                res.inverse    = 31'(1 % m);
                res.no_inverse = (m != 1);
            end
            else begin
                r0 = m;
                r1 = v % m;
                t0 = 0;
                t1 = 1;
                while (r1 != 0) begin
                    q  = r0 / r1;
                    nr = r0 - q * r1;
                    nt = t0 - longint'(q) * t1;
                    r0 = r1;
                    r1 = nr;
                    t0 = t1;
                    t1 = nt;
                end
                x = t0 % longint'(m);
                if (x < 0)
                    x = x + longint'(m);
                res.inverse    = x[30:0];
                res.no_inverse = (r0 != 1);
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [30:0] inv, logic flag);
            inverse_result_t exp_res;
            if (expected_q.size() == 0) begin
                $error("result with nothing outstanding: inverse %0d, no_inverse %0d",
                       inv, flag);
                failures++;
                return;
            end
            exp_res = expected_q.pop_front();
            results_checked++;
            if (flag)
                no_inverse_seen++;
            if (inv !== exp_res.inverse) begin
                $error("inverse: expected %0d, actual %0d", exp_res.inverse, inv);
                failures++;
            end
            if (flag !== exp_res.no_inverse) begin
                $error("no_inverse: expected %0d, actual %0d", exp_res.no_inverse, flag);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [62:0] value = '0;
    logic        done;
    logic [30:0] inverse;
    logic        no_inverse;

    inverse_scoreboard sb = new();
    int unsigned       quiet_cycles;
    int unsigned       values_sent;
    int unsigned       modulus_settings;

    modular_inverse #(
        .VALUE_BITS(63),
        .MOD_BITS  (31)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .done      (done),
        .inverse   (inverse),
        .no_inverse(no_inverse)
    );

    always #5 clk = ~clk;

    // Monitor. Everything is sampled at the rising edge, before the block and
    // the drivers update, so each observation reflects what the block saw at
    // that edge. A result is checked before a command accepted at the same
    // edge is noted; the FIFO order makes this harmless either way.
    always @(posedge clk)
    begin
        logic any_transfer;
        any_transfer = 1'b0;
        if (rst_n) begin
            if (done) begin
                sb.check_result(inverse, no_inverse);
                any_transfer = 1'b1;
            end
            if (start && !busy) begin
                sb.note_value(value);
                any_transfer = 1'b1;
            end
            if (psel && penable && pready) begin
                any_transfer = 1'b1;
                if (pwrite && paddr == MODULUS_ADDR)
                    sb.set_modulus(pwdata);
                else if (!pwrite && paddr == MODULUS_ADDR
                         && prdata !== {1'b0, sb.modulus}) begin
                    $error("modulus: expected %0d, actual %0d", sb.modulus, prdata);
                    sb.failures++;
                end
            end
        end
        // The watchdog only counts stretches in which no transfer of any kind
        // happens; a long Euclid run or an idle gap is far below the limit.
        if (any_transfer)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.expected_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One command transfer. The caller has just returned from a clock edge;
    // start rises here and stays high until the block takes the value. When
    // the next value follows at once, start is simply left high.
    task automatic send_value(input logic [62:0] v);
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        values_sent++;
    endtask

    // Writes the modulus with a setup and an access cycle, then reads it back
    // so the monitor can compare the register against the predicted copy.
    task automatic write_modulus(input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= MODULUS_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        modulus_settings++;
    endtask

    // The block must be idle before the register changes: start is low and
    // every predicted result has come back.
    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Draws a value that exercises the interesting corners for modulus m:
    // full-width noise, values below and around m, exact multiples (which have
    // no inverse), near-multiples, single set bits and values close to the
    // top of the 63-bit range.
    function automatic logic [62:0] pick_value(input logic [30:0] m);
        longint unsigned prod;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {$urandom, $urandom};
            4:          return 63'($urandom_range(0, 32'(m) + 2));
            5:
            begin
                prod = longint'(m) * longint'($urandom);
                return prod[62:0];
            end
            6:          return 63'(m) + 63'($urandom_range(0, 2)) - 63'd1;
            7:          return {63{1'b1}} - 63'($urandom_range(0, 1000));
            8:          return 63'(1) << $urandom_range(0, 62);
            default:
            begin
                prod = longint'(m) * longint'($urandom_range(1, 1 << 20))
                       + longint'($urandom_range(0, 3));
                return prod[62:0];
            end
        endcase
    endfunction

    // Random part at the current modulus. Start drops for a gap after about
    // one transfer in five; most gaps are short, a few are long enough to
    // land anywhere inside the next computation. Values 300 to 500 of the
    // run go back to back.
    task automatic run_random_phase(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            send_value(pick_value(sb.modulus));
            if (i + 1 < count && (values_sent < 300 || values_sent > 500)
                && $urandom_range(0, 99) < 21) begin
                start <= 1'b0;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(9, 300)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        logic [62:0] directed[$];
        logic [31:0] moduli[$];
        longint unsigned rm;
        int unsigned k;

        quiet_cycles     = 0;
        values_sent      = 0;
        modulus_settings = 1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run at the reset modulus without any write, so the
        // reset value of the register is covered as well.
        rm = longint'(MOD_RESET);
        directed = '{
            63'd0, 63'd1, 63'd2, 63'd3,
            63'(rm - 1), 63'(rm), 63'(rm + 1), 63'(2 * rm),
            63'(rm * rm), 63'(rm << 31),
            63'd500000004, 63'h7FFF_FFFF,
            {63{1'b1}}, 63'(1) << 62,
            {31'h5555_5555, 32'h5555_5555}, {31'h2AAA_AAAA, 32'hAAAA_AAAA}
        };
        foreach (directed[i])
            send_value(directed[i]);
        wait_until_drained();

        // Modulus settings: the smallest and largest legal values, small
        // primes, a power of two and composites (many values share a factor),
        // the degenerate zero and one, a random one, and the reset value
        // written back explicitly. Bit 31 of the write data is random and
        // must be dropped by the 31-bit register.
        moduli = '{
            32'd2, 32'h7FFF_FFFF, 32'd3, 32'h4000_0000, 32'd999999000,
            32'd111546435, 32'd0, 32'd1,
            32'($urandom_range(2, 32'h7FFF_FFFF)), 32'd1000000007
        };
        foreach (moduli[i]) begin
            write_modulus({1'($urandom_range(0, 1)), moduli[i][30:0]});
            @(posedge clk);
            k = (moduli[i][30:0] < 2) ? TRIVIAL_PHASE_ITEMS : PHASE_ITEMS;
            run_random_phase(k);
            wait_until_drained();
        end

        // Nothing is outstanding now; give the block time to show any extra
        // result strobe before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d values over %0d modulus settings; checked %0d results,",
                 values_sent, modulus_settings, sb.results_checked);
        $display("%0d of them without an inverse.", sb.no_inverse_seen);
        if (sb.failures == 0 && sb.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* modular_inverse.f */
hdl/modinv_pkg.sv
hdl/modinv_alu.sv
hdl/modular_inverse.sv
bench/tb_modular_inverse.sv
